// ===== design/packed_utf8_to_utf32_top_macros.svh =====
// Assertion macros for the packed UTF-8 to UTF-32 decoder checker.
`ifndef PACKED_UTF8_TO_UTF32_TOP_MACROS_SVH
`define PACKED_UTF8_TO_UTF32_TOP_MACROS_SVH

// Checked only while reset is released.
`define P8U32_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define P8U32_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/p8u32_pkg.sv =====
// Shared types and constants of the packed UTF-8 to UTF-32 decoder.
`timescale 1ns / 1ps

package p8u32_pkg;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  localparam logic [31:0] MIN_4B      = 32'hf090_8080;
  localparam logic [31:0] MAX_4B      = 32'hf48f_bfbf;
  localparam logic [23:0] MIN_3B      = 24'he0_a080;
  localparam logic [23:0] SURR_LO     = 24'hed_a080;
  localparam logic [23:0] SURR_HI     = 24'hed_bfbf;
  localparam logic [15:0] MIN_2B      = 16'hc280;
  localparam logic [31:0] REPLACEMENT = 32'h0000_fffd;

  // Classified word, between the class stage and the decode stage.
  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic [2:0]  len;
    logic        pat_ok;
  } class_stg_t;

  // Decoded character, between the decode stage and the output stage.
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [20:0] cp;
    logic [2:0]  len;
  } dec_stg_t;

endpackage

// ===== design/p8u32_class.sv =====
// Input register, length classification and lead/continuation bit checks.
`timescale 1ns / 1ps

module p8u32_class (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [31:0]            in_word,
  output p8u32_pkg::class_stg_t  cls_o
);

  logic        v0_r;
  logic [31:0] w0_r;
  logic [2:0]  len_nxt;
  logic        pat_nxt;
  p8u32_pkg::class_stg_t cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    w0_r <= in_word;
  end

  always_comb begin
    priority if (w0_r[31:24] != 8'h00) begin
      len_nxt = p8u32_pkg::LEN_4;
    end else if (w0_r[23:16] != 8'h00) begin
      len_nxt = p8u32_pkg::LEN_3;
    end else if (w0_r[15:8] != 8'h00) begin
      len_nxt = p8u32_pkg::LEN_2;
    end else begin
      len_nxt = p8u32_pkg::LEN_1;
    end
  end

  always_comb begin
    unique case (len_nxt)
      p8u32_pkg::LEN_4: begin
        pat_nxt = (w0_r[31:27] == 5'b11110) && (w0_r[23:22] == 2'b10) &&
                  (w0_r[15:14] == 2'b10) && (w0_r[7:6] == 2'b10);
      end
      p8u32_pkg::LEN_3: begin
        pat_nxt = (w0_r[23:20] == 4'b1110) && (w0_r[15:14] == 2'b10) &&
                  (w0_r[7:6] == 2'b10);
      end
      p8u32_pkg::LEN_2: begin
        pat_nxt = (w0_r[15:13] == 3'b110) && (w0_r[7:6] == 2'b10);
      end
      default: begin
        pat_nxt = ~w0_r[7];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r.valid <= 1'b0;
    end else begin
      cls_r.valid <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    cls_r.word   <= w0_r;
    cls_r.len    <= len_nxt;
    cls_r.pat_ok <= pat_nxt;
  end

  assign cls_o = cls_r;

endmodule

// ===== design/p8u32_decode.sv =====
// Range checks (overlong, surrogate, upper limit) and code point extraction.
`timescale 1ns / 1ps

module p8u32_decode (
  input  logic                   clk,
  input  logic                   rst_n,
  input  p8u32_pkg::class_stg_t  cls_i,
  output p8u32_pkg::dec_stg_t    dec_o
);

  logic        range_ok;
  logic [20:0] cp_nxt;
  p8u32_pkg::dec_stg_t dec_r;

  always_comb begin
    unique case (cls_i.len)
      p8u32_pkg::LEN_4: begin
        range_ok = (cls_i.word >= p8u32_pkg::MIN_4B) &&
                   (cls_i.word <= p8u32_pkg::MAX_4B);
        cp_nxt   = {cls_i.word[26:24], cls_i.word[21:16], cls_i.word[13:8],
                    cls_i.word[5:0]};
      end
      p8u32_pkg::LEN_3: begin
        range_ok = (cls_i.word[23:0] >= p8u32_pkg::MIN_3B) &&
                   ((cls_i.word[23:0] < p8u32_pkg::SURR_LO) ||
                    (cls_i.word[23:0] > p8u32_pkg::SURR_HI));
        cp_nxt   = {5'd0, cls_i.word[19:16], cls_i.word[13:8], cls_i.word[5:0]};
      end
      p8u32_pkg::LEN_2: begin
        range_ok = (cls_i.word[15:0] >= p8u32_pkg::MIN_2B);
        cp_nxt   = {10'd0, cls_i.word[12:8], cls_i.word[5:0]};
      end
      default: begin
        range_ok = 1'b1;
        cp_nxt   = {14'd0, cls_i.word[6:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else begin
      dec_r.valid <= cls_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    dec_r.ok  <= cls_i.pat_ok && range_ok;
    dec_r.cp  <= cp_nxt;
    dec_r.len <= cls_i.len;
  end

  assign dec_o = dec_r;

endmodule

// ===== design/packed_utf8_to_utf32_top.sv =====
// Top level of the packed UTF-8 to UTF-32 decoder.
//
//   channel  ports                                      handshake
//   input    in_packed_utf8                             start, busy
//   result   out_code_word, out_is_valid, out_byte_length  out_strobe
//   config   cfg_wdata                                  cfg_we
//
// A request may be issued every cycle; busy stays low after reset.
// Each request gives one result, passing through the four register
// stages: input, classification, decode, output.
// Synchronous active-low reset clears all stage valid bits and the endian bit.
// Results are shown for one cycle on out_strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module packed_utf8_to_utf32_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_packed_utf8,
  output logic        out_strobe,
  output logic [31:0] out_code_word,
  output logic        out_is_valid,
  output logic [2:0]  out_byte_length,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  p8u32_pkg::class_stg_t cls;
  p8u32_pkg::dec_stg_t   dec;

  logic        le_r;
  logic        strobe_r;
  logic [31:0] code_r;
  logic        valid_r;
  logic [2:0]  len_r;
  logic [31:0] cp_word;
  logic [31:0] code_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r <= 1'b0;
    end else if (cfg_we) begin
      le_r <= cfg_wdata;
    end
  end

  p8u32_class u_class (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_word (in_packed_utf8),
    .cls_o   (cls)
  );

  p8u32_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .cls_i (cls),
    .dec_o (dec)
  );

  assign cp_word  = dec.ok ? {11'd0, dec.cp} : p8u32_pkg::REPLACEMENT;
  assign code_nxt = le_r ? {cp_word[7:0], cp_word[15:8], cp_word[23:16], cp_word[31:24]}
                         : cp_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dec.valid;
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    valid_r <= dec.ok;
    len_r   <= dec.len;
  end

  assign out_strobe      = strobe_r;
  assign out_code_word   = code_r;
  assign out_is_valid    = valid_r;
  assign out_byte_length = len_r;

endmodule

// ===== design/p8u32_checker.sv =====
// Port-level checker for the packed UTF-8 to UTF-32 decoder, with its bind.
`timescale 1ns / 1ps
`include "packed_utf8_to_utf32_top_macros.svh"

module p8u32_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_packed_utf8,
  input logic        out_strobe,
  input logic [31:0] out_code_word,
  input logic        out_is_valid,
  input logic [2:0]  out_byte_length,
  input logic        cfg_we,
  input logic        cfg_wdata
);

  // Every accepted request shows up as a result on out_strobe, and every result has a request.
  `P8U32_ASSERT(a_req_to_result, (start && !busy) |-> ##4 out_strobe, "request lost")
  `P8U32_ASSERT(a_result_has_req, out_strobe |-> $past(start && !busy, 4), "result invented")
  `P8U32_ASSERT(a_len_range, out_strobe |-> (out_byte_length == 3'd1 || out_byte_length == 3'd2 || out_byte_length == 3'd3 || out_byte_length == 3'd4), "bad length class")
  `P8U32_ASSERT(a_bad_gives_fffd, (out_strobe && !out_is_valid) |-> (out_code_word == 32'h0000_fffd || out_code_word == 32'hfdff_0000), "invalid char without replacement")
  `P8U32_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_strobe, "result right after reset")

endmodule

bind packed_utf8_to_utf32_top p8u32_checker u_p8u32_checker (.*);
